// ===== rtl/core/vapf_pkg.sv =====
// vapf_pkg: shared types, constants and helpers for the volume axis permute/flip block
// no dependencies; imported by vapf_map and volume_axis_permute_flip_top
package vapf_pkg;

	localparam int MAX_EXTENT = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int AXES       = 3;
	localparam int COORD_W    = $clog2(MAX_EXTENT);
	localparam int EXT_W      = COORD_W + 1;
	localparam int CFG_W      = EXT_W;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [EXT_W-1:0]   extent_t;
	typedef logic [1:0]         axis_code_t;

	// source axis codes
	localparam axis_code_t AXIS_X   = 2'd0;
	localparam axis_code_t AXIS_Y   = 2'd1;
	localparam axis_code_t AXIS_Z   = 2'd2;
	localparam axis_code_t AXIS_BAD = 2'd3;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SIZE_X    = 3'd0,
		REG_SIZE_Y    = 3'd1,
		REG_SIZE_Z    = 3'd2,
		REG_TWO_DIM   = 3'd3,
		REG_AXIS_OUTX = 3'd4,
		REG_AXIS_OUTY = 3'd5,
		REG_AXIS_OUTZ = 3'd6,
		REG_FLIP_MASK = 3'd7
	} reg_index_t;

	typedef struct packed {
		extent_t    size_x;
		extent_t    size_y;
		extent_t    size_z;
		logic       two_dim_mode;
		axis_code_t axis_for_out_x;
		axis_code_t axis_for_out_y;
		axis_code_t axis_for_out_z;
		logic [2:0] flip_mask;
	} cfg_t;

	typedef struct packed {
		coord_t dest_x;
		coord_t dest_y;
		coord_t dest_z;
		logic   bad_permutation;
	} map_res_t;

	// largest coordinate of an axis: extent-1, with extent clamped to 1..MAX_EXTENT
	function automatic coord_t last_coord(input extent_t size);
		coord_t r;
		if (size == '0) begin
			r = '0;
		end else if (size > extent_t'(MAX_EXTENT)) begin
			r = coord_t'(MAX_EXTENT - 1);
		end else begin
			r = coord_t'(size - extent_t'(1));
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/volume_axis_permute_flip_top.sv =====
// volume_axis_permute_flip_top: raster voxel stream to permuted/flipped destination coordinates
// depends on vapf_pkg and vapf_map
//
// Usage: voxels enter in raster order (x fastest, then y, then z) on the input channel
// (in_valid/in_stall/voxel_value). Each beat yields one output beat carrying the same
// word, its destination coordinates, a last-voxel mark and an axis-selection error flag.
// A beat moves when valid is high and stall is low.
// Pipeline: position capture register, then result register holding the mapped coordinates.
// Throughput: one voxel per cycle unless the receiver stalls; the position counters advance
// once per accepted beat.
// Both stages fill while the receiver stalls; in_stall rises only when both are full,
// and the waiting result holds steady.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; write only while
// the block is empty. Counters are not cleared by configuration writes.
// Reset: counters return to zero, registers to sizes 1, 3-d mode, identity axes, no flip,
// and both stages empty.
module volume_axis_permute_flip_top
	import vapf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_WIDTH-1:0] voxel_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] voxel_value_out,
	output coord_t                dest_x,
	output coord_t                dest_y,
	output coord_t                dest_z,
	output logic                  last_voxel,
	output logic                  bad_permutation
);

	cfg_t     cfg_q;
	coord_t   count_x_q, count_y_q, count_z_q;
	logic     valid_s1, valid_s2;
	logic [DATA_WIDTH-1:0] data_s1, data_s2;
	coord_t   cx_s1, cy_s1, cz_s1;
	logic     last_s1, last_s2;
	map_res_t map_res, res_s2;
	logic     adv_s2, adv_s1, in_acc;
	logic     end_x, end_y, end_z;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x         <= extent_t'(1);
			cfg_q.size_y         <= extent_t'(1);
			cfg_q.size_z         <= extent_t'(1);
			cfg_q.two_dim_mode   <= 1'b0;
			cfg_q.axis_for_out_x <= AXIS_X;
			cfg_q.axis_for_out_y <= AXIS_Y;
			cfg_q.axis_for_out_z <= AXIS_Z;
			cfg_q.flip_mask      <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SIZE_X:    cfg_q.size_x         <= cfg_data;
				REG_SIZE_Y:    cfg_q.size_y         <= cfg_data;
				REG_SIZE_Z:    cfg_q.size_z         <= cfg_data;
				REG_TWO_DIM:   cfg_q.two_dim_mode   <= cfg_data[0];
				REG_AXIS_OUTX: cfg_q.axis_for_out_x <= cfg_data[1:0];
				REG_AXIS_OUTY: cfg_q.axis_for_out_y <= cfg_data[1:0];
				REG_AXIS_OUTZ: cfg_q.axis_for_out_z <= cfg_data[1:0];
				REG_FLIP_MASK: cfg_q.flip_mask      <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	always_comb begin
		adv_s2   = !valid_s2 || !out_stall;
		adv_s1   = !valid_s1 || adv_s2;
		in_stall = !adv_s1;
		in_acc   = in_valid && adv_s1;
	end

	// end-of-axis tests on the current position
	always_comb begin
		end_x = count_x_q >= last_coord(cfg_q.size_x);
		end_y = count_y_q >= last_coord(cfg_q.size_y);
		end_z = cfg_q.two_dim_mode || (count_z_q >= last_coord(cfg_q.size_z));
	end

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_x_q <= '0;
			count_y_q <= '0;
			count_z_q <= '0;
		end else if (in_acc) begin
			if (!end_x) begin
				count_x_q <= count_x_q + coord_t'(1);
			end else begin
				count_x_q <= '0;
				if (!end_y) begin
					count_y_q <= count_y_q + coord_t'(1);
				end else begin
					count_y_q <= '0;
					count_z_q <= end_z ? '0 : count_z_q + coord_t'(1);
				end
			end
		end
	end

	// stage 1: capture beat and its source position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= voxel_value;
			cx_s1   <= count_x_q;
			cy_s1   <= count_y_q;
			cz_s1   <= count_z_q;
			last_s1 <= end_x && end_y && end_z;
		end
	end

	vapf_map u_map (
		.cfg     (cfg_q),
		.count_x (cx_s1),
		.count_y (cy_s1),
		.count_z (cz_s1),
		.res     (map_res)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2 <= data_s1;
			res_s2  <= map_res;
			last_s2 <= last_s1;
		end
	end

	assign out_valid       = valid_s2;
	assign voxel_value_out = data_s2;
	assign dest_x          = res_s2.dest_x;
	assign dest_y          = res_s2.dest_y;
	assign dest_z          = res_s2.dest_z;
	assign last_voxel      = last_s2;
	assign bad_permutation = res_s2.bad_permutation;

endmodule

// ===== rtl/core/vapf_map.sv =====
// vapf_map: maps a source voxel position to destination coordinates, checks axis selection
// depends on vapf_pkg
module vapf_map
	import vapf_pkg::*;
(
	input  cfg_t     cfg,
	input  coord_t   count_x,
	input  coord_t   count_y,
	input  coord_t   count_z,
	output map_res_t res
);

	coord_t     crd [AXES];
	coord_t     lim [AXES];
	axis_code_t code [AXES];
	logic [1:0] sel [AXES];
	coord_t     dst [AXES];
	logic       bad;
	logic [2:0] used;

	// source coordinates and last coordinates, z collapsed in 2-d mode
	always_comb begin
		crd[0] = count_x;
		crd[1] = count_y;
		crd[2] = cfg.two_dim_mode ? '0 : count_z;
		lim[0] = last_coord(cfg.size_x);
		lim[1] = last_coord(cfg.size_y);
		lim[2] = cfg.two_dim_mode ? '0 : last_coord(cfg.size_z);
		code[0] = cfg.axis_for_out_x;
		code[1] = cfg.axis_for_out_y;
		code[2] = cfg.axis_for_out_z;
		used = cfg.two_dim_mode ? 3'b011 : 3'b111;
	end

	// per output axis: pick source, optionally flip
	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			sel[i] = (code[i] == AXIS_BAD) ? AXIS_Z : code[i];
			dst[i] = cfg.flip_mask[i] ? coord_t'(lim[sel[i]] - crd[sel[i]]) : crd[sel[i]];
		end
	end

	// invalid selection: code 3, z in 2-d mode, or duplicate among used axes
	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			if (used[i] && code[i] == AXIS_BAD) bad = 1'b1;
			if (used[i] && cfg.two_dim_mode && sel[i] == AXIS_Z) bad = 1'b1;
		end
		if (sel[0] == sel[1]) bad = 1'b1;
		if (used[2] && (sel[0] == sel[2] || sel[1] == sel[2])) bad = 1'b1;
	end

	always_comb begin
		res.dest_x          = dst[0];
		res.dest_y          = dst[1];
		res.dest_z          = cfg.two_dim_mode ? '0 : dst[2];
		res.bad_permutation = bad;
	end

endmodule

// ===== tb/testbench.sv =====
// testbench for volume_axis_permute_flip_top: raster voxel stream against a coordinate predictor
// depends on vapf_pkg and the block's rtl; random idling and stalls on both channels
module testbench;
	import vapf_pkg::*;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		coord_t                dx;
		coord_t                dy;
		coord_t                dz;
		logic                  last;
		logic                  bad;
	} voxel_beat_t;

	// tracks register copies and position counters, queues the beats the block owes
	class reorient_predictor;
		extent_t     size [3];
		logic        two_dim;
		axis_code_t  axis_code [3];
		logic [2:0]  flip;
		coord_t      count [3];
		voxel_beat_t due_beats [$];
		int          errors;

		function new();
			size[0] = extent_t'(1);
			size[1] = extent_t'(1);
			size[2] = extent_t'(1);
			two_dim = 1'b0;
			axis_code[0] = AXIS_X;
			axis_code[1] = AXIS_Y;
			axis_code[2] = AXIS_Z;
			flip = 3'd0;
			count[0] = '0;
			count[1] = '0;
			count[2] = '0;
			errors = 0;
		endfunction

		static function int unsigned usable_extent(extent_t s);
			if (s == '0)
				return 1;
			if (s > extent_t'(MAX_EXTENT))
				return MAX_EXTENT;
			return s;
		endfunction

		function void set_reg(reg_index_t idx, extent_t d);
			case (idx)
				REG_SIZE_X:    size[0] = d;
				REG_SIZE_Y:    size[1] = d;
				REG_SIZE_Z:    size[2] = d;
				REG_TWO_DIM:   two_dim = d[0];
				REG_AXIS_OUTX: axis_code[0] = d[1:0];
				REG_AXIS_OUTY: axis_code[1] = d[1:0];
				REG_AXIS_OUTZ: axis_code[2] = d[1:0];
				REG_FLIP_MASK: flip = d[2:0];
				default: ;
			endcase
		endfunction

		function void note_voxel(logic [DATA_WIDTH-1:0] v);
			int unsigned ext [3];
			int unsigned crd [3];
			int unsigned sel [3];
			int unsigned c;
			int          used;
			int          i;
			int          j;
			bit          bad;
			bit          end_x;
			bit          end_y;
			bit          end_z;
			coord_t      dst [3];
			voxel_beat_t b;
			used = two_dim ? 2 : 3;
			bad = 1'b0;
			ext[0] = usable_extent(size[0]);
			ext[1] = usable_extent(size[1]);
			ext[2] = two_dim ? 1 : usable_extent(size[2]);
			crd[0] = count[0];
			crd[1] = count[1];
			crd[2] = two_dim ? 0 : count[2];
			// axis selection and its error conditions
			for (i = 0; i < 3; i++) begin
				sel[i] = (axis_code[i] == AXIS_BAD) ? AXIS_Z : axis_code[i];
				if (i < used) begin
					if (axis_code[i] == AXIS_BAD)
						bad = 1'b1;
					if (two_dim && sel[i] == AXIS_Z)
						bad = 1'b1;
				end
			end
			for (i = 0; i < used; i++)
				for (j = i + 1; j < used; j++)
					if (sel[i] == sel[j])
						bad = 1'b1;
			// destination coordinates, flipped ones wrap to coordinate width
			for (i = 0; i < 3; i++) begin
				c = crd[sel[i]];
				if (flip[i])
					c = ext[sel[i]] - 1 - c;
				dst[i] = coord_t'(c);
			end
			if (two_dim)
				dst[2] = '0;
			end_x = count[0] >= ext[0] - 1;
			end_y = count[1] >= ext[1] - 1;
			end_z = two_dim ? 1'b1 : (count[2] >= ext[2] - 1);
			b.value = v;
			b.dx = dst[0];
			b.dy = dst[1];
			b.dz = dst[2];
			b.last = end_x && end_y && end_z;
			b.bad = bad;
			due_beats = {due_beats, b};
			// raster counter advance
			if (!end_x) begin
				count[0] = count[0] + 1'b1;
			end else begin
				count[0] = '0;
				if (!end_y) begin
					count[1] = count[1] + 1'b1;
				end else begin
					count[1] = '0;
					if (two_dim || end_z)
						count[2] = '0;
					else
						count[2] = count[2] + 1'b1;
				end
			end
		endfunction

		function void check_beat(voxel_beat_t got);
			voxel_beat_t want;
			if (due_beats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output beat: value %h dest %0d %0d %0d last %b bad %b",
						got.value, got.dx, got.dy, got.dz, got.last, got.bad);
				return;
			end
			want = due_beats.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: expected value %h dest %0d %0d %0d last %b bad %b",
						want.value, want.dx, want.dy, want.dz, want.last, want.bad);
					$display("          actual   value %h dest %0d %0d %0d last %b bad %b",
						got.value, got.dx, got.dy, got.dz, got.last, got.bad);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [DATA_WIDTH-1:0] voxel_value;
	logic                  out_valid;
	logic                  out_stall;
	logic [DATA_WIDTH-1:0] voxel_value_out;
	coord_t                dest_x;
	coord_t                dest_y;
	coord_t                dest_z;
	logic                  last_voxel;
	logic                  bad_permutation;

	reorient_predictor board;
	bit                quiet;
	int                hold_cycles;

	volume_axis_permute_flip_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.voxel_value     (voxel_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.voxel_value_out (voxel_value_out),
		.dest_x          (dest_x),
		.dest_y          (dest_y),
		.dest_z          (dest_z),
		.last_voxel      (last_voxel),
		.bad_permutation (bad_permutation)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// output beat monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_beat('{voxel_value_out, dest_x, dest_y, dest_z, last_voxel,
				bad_permutation});
	end

	// receiver stall: random, or one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 6);
			end
		end
	end

	function automatic logic [DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic extent_t pick_extent();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return extent_t'($urandom_range(1, 6));
		if (r < 85)
			return '0;
		if (r < 90)
			return extent_t'(MAX_EXTENT);
		if (r < 95)
			return '1;
		return extent_t'($urandom_range(7, MAX_EXTENT));
	endfunction

	// one input beat, with an occasional gap ahead of it
	task automatic send_voxel(input logic [DATA_WIDTH-1:0] v);
		if (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		voxel_value <= v;
		do @(posedge clk); while (in_stall);
		board.note_voxel(v);
	endtask

	// stop sending and wait for every owed beat
	task automatic drain();
		in_valid <= 1'b0;
		while (board.due_beats.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input extent_t d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		board.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic load_config(input extent_t sx, input extent_t sy, input extent_t sz,
		input logic two, input axis_code_t ax, input axis_code_t ay, input axis_code_t az,
		input logic [2:0] fm);
		drain();
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, sz);
		write_reg(REG_TWO_DIM, extent_t'(two));
		write_reg(REG_AXIS_OUTX, extent_t'(ax));
		write_reg(REG_AXIS_OUTY, extent_t'(ay));
		write_reg(REG_AXIS_OUTZ, extent_t'(az));
		write_reg(REG_FLIP_MASK, extent_t'(fm));
		cfg_we <= 1'b0;
	endtask

	// run limit
	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int          random_sent;
		int          n;
		int          a;
		int          b;
		int unsigned vol;
		bit          held;
		logic        two;
		extent_t     sx;
		extent_t     sy;
		extent_t     sz;
		axis_code_t  ax;
		axis_code_t  ay;
		axis_code_t  az;
		board = new();
		quiet = 1'b0;
		hold_cycles = 0;
		held = 1'b0;
		random_sent = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		voxel_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SIZE_X;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single-voxel volume, every beat is last
		send_voxel('0);
		send_voxel('1);
		// 3-d rotation with flips, stopped mid-volume
		load_config(3, 2, 2, 1'b0, AXIS_Z, AXIS_X, AXIS_Y, 3'd5);
		repeat (5) send_voxel(pick_word());
		// zero and oversized extents, counters now beyond the new extents
		load_config(0, '1, extent_t'(MAX_EXTENT), 1'b0, AXIS_Y, AXIS_Z, AXIS_X, 3'd7);
		repeat (3) send_voxel(pick_word());
		// 2-d swap, z axis code ignored
		load_config(4, 3, 9, 1'b1, AXIS_Y, AXIS_X, AXIS_BAD, 3'd3);
		repeat (4) send_voxel(pick_word());
		// z selected in 2-d mode
		load_config(3, 3, 5, 1'b1, AXIS_Z, AXIS_X, AXIS_Y, 3'd1);
		repeat (2) send_voxel(pick_word());
		// axis code 3 in 3-d mode
		load_config(2, 2, 2, 1'b0, AXIS_BAD, AXIS_Y, AXIS_X, 3'd2);
		repeat (2) send_voxel(pick_word());
		// duplicate axes, 3-d then 2-d
		load_config(2, 3, 2, 1'b0, AXIS_X, AXIS_X, AXIS_Z, 3'd4);
		repeat (2) send_voxel(pick_word());
		load_config(5, 2, 1, 1'b1, AXIS_Y, AXIS_Y, AXIS_Z, 3'd6);
		repeat (2) send_voxel(pick_word());

		// random settings, mostly valid permutations over whole small volumes
		while (random_sent < 650) begin
			two = ($urandom_range(0, 3) == 0);
			sx = pick_extent();
			sy = pick_extent();
			sz = pick_extent();
			if ($urandom_range(0, 99) < 85) begin
				if (two) begin
					a = $urandom_range(0, 1);
					ax = axis_code_t'(a);
					ay = axis_code_t'(1 - a);
					az = axis_code_t'($urandom_range(0, 3));
				end else begin
					a = $urandom_range(0, 2);
					b = (a + $urandom_range(1, 2)) % 3;
					ax = axis_code_t'(a);
					ay = axis_code_t'(b);
					az = axis_code_t'(3 - a - b);
				end
			end else begin
				ax = axis_code_t'($urandom_range(0, 3));
				ay = axis_code_t'($urandom_range(0, 3));
				az = axis_code_t'($urandom_range(0, 3));
			end
			load_config(sx, sy, sz, two, ax, ay, az, 3'($urandom_range(0, 7)));
			quiet = (random_sent >= 150 && random_sent < 300);
			vol = reorient_predictor::usable_extent(sx) * reorient_predictor::usable_extent(sy)
				* (two ? 1 : reorient_predictor::usable_extent(sz));
			if (vol <= 120)
				n = vol * $urandom_range(1, 2) + $urandom_range(0, 3);
			else
				n = $urandom_range(10, 40);
			// keep the total near the planned beat count
			if (n > 650 - random_sent)
				n = 650 - random_sent;
			// long receiver hold-off while the sender keeps offering beats
			if (!held && random_sent >= 350) begin
				held = 1'b1;
				quiet = 1'b1;
				hold_cycles = 80;
				n = n + 30;
			end
			repeat (n) begin
				send_voxel(pick_word());
				random_sent++;
			end
			quiet = 1'b0;
		end

		// wait out the pipeline
		in_valid <= 1'b0;
		while (board.due_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
